// ===== rtl/core/rwcw_pkg.sv =====
// Package for the RIFF/WAVE chunk walker: phase encoding, tag constants and
// the result item type. No dependencies.
package rwcw_pkg;

    typedef enum logic [5:0] {
        PH_RIFF = 6'b000001,
        PH_HDR  = 6'b000010,
        PH_BODY = 6'b000100,
        PH_FMT  = 6'b001000,
        PH_PAD  = 6'b010000,
        PH_DEAD = 6'b100000
    } phase_t;

    localparam logic [31:0] RIFF_TAG = 32'h52494646;
    localparam logic [31:0] WAVE_TAG = 32'h57415645;
    localparam logic [31:0] DATA_TAG = 32'h64617461;
    localparam logic [31:0] FMT_TAG  = 32'h666D7420;

    localparam logic [31:0] FMT_MIN_SIZE    = 32'd16;
    localparam logic [3:0]  RIFF_HDR_BYTES  = 4'd12;
    localparam logic [3:0]  CHUNK_HDR_BYTES = 4'd8;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        done_res;
        logic        is_wave;
        logic        data_found;
        logic [31:0] data_length;
        logic [31:0] rate_hz;
    } result_t;

endpackage

// ===== rtl/core/riff_wave_chunk_walker_top.sv =====
// Top level of the RIFF/WAVE chunk walker: header check, chunk walk and
// output register with skid stage. Depends on rwcw_pkg.
//
// The source channel (src_valid, src_stall) carries one buffer byte per item,
// with end_of_buffer set on the last byte. The destination channel
// (dst_valid, dst_stall) returns exactly one result item per input item.
// A result shows payload_valid and payload_byte for each byte of the first
// data chunk body, and on the last byte of the buffer done_res together with
// is_wave, data_found, data_length and rate_hz.
// Each result is registered in the result register, or in the skid register,
// and one item is taken in every cycle while src_stall is low: all per-byte
// work is a compare and a counter update between state and result registers.
// When the receiver stalls, the result register holds and one more item is
// caught in the skid register; src_stall rises only while the skid register
// is full. After the last byte the walker returns to its reset state, so the
// next byte starts a new buffer.
// Reset is asynchronous and active low; it empties both result registers and
// puts the walker at the start of the RIFF header.
module riff_wave_chunk_walker_top #(
    parameter int LENGTH_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        src_valid,
    output logic        src_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_buffer,
    output logic        dst_valid,
    input  logic        dst_stall,
    output logic        payload_valid,
    output logic [7:0]  payload_byte,
    output logic        done_res,
    output logic        is_wave,
    output logic        data_found,
    output logic [31:0] data_length,
    output logic [31:0] rate_hz
);
    import rwcw_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [3:0]             byte_in_field_reg, byte_in_field_next;
    logic                   header_ok_reg, header_ok_next;
    logic [31:0]            chunk_tag_reg, chunk_tag_next;
    logic [31:0]            chunk_length_reg, chunk_length_next;
    logic [LENGTH_BITS-1:0] body_remaining_reg, body_remaining_next;
    logic                   pad_pending_reg, pad_pending_next;
    logic                   data_seen_reg, data_seen_next;
    logic                   in_data_body_reg, in_data_body_next;
    logic [LENGTH_BITS-1:0] payload_count_reg, payload_count_next;
    logic                   rate_seen_reg, rate_seen_next;
    logic [31:0]            rate_value_reg, rate_value_next;

    result_t                res;
    result_t                out_reg, out_next;
    result_t                skid_reg, skid_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   skid_valid_reg, skid_valid_next;

    logic                   src_fire;
    logic                   dst_fire;
    logic [31:0]            asm_len;
    logic [LENGTH_BITS+31:0] len_ext;
    logic [LENGTH_BITS-1:0] len_sat;

    assign src_stall = skid_valid_reg;
    assign src_fire  = src_valid && !src_stall;
    assign dst_fire  = out_valid_reg && !dst_stall;

    // The chunk size as it stands once the current byte is placed, and
    // the size saturated to the counter range.
    assign asm_len = chunk_length_reg
                     | ({24'b0, data_byte} << {byte_in_field_reg[1:0], 3'b000});
    assign len_ext = {{LENGTH_BITS{1'b0}}, asm_len};
    assign len_sat = (|(len_ext >> LENGTH_BITS)) ? {LENGTH_BITS{1'b1}}
                                                 : len_ext[LENGTH_BITS-1:0];

    always_comb
    begin
        logic [3:0]              idx4;
        logic [2:0]              idx3;
        logic [LENGTH_BITS-1:0]  body_dec;
        logic [LENGTH_BITS+31:0] cnt_ext;

        idx4                = byte_in_field_reg;
        idx3                = byte_in_field_reg[2:0];
        body_dec            = body_remaining_reg;
        cnt_ext             = '0;

        phase_next          = phase_reg;
        byte_in_field_next  = byte_in_field_reg;
        header_ok_next      = header_ok_reg;
        chunk_tag_next      = chunk_tag_reg;
        chunk_length_next   = chunk_length_reg;
        body_remaining_next = body_remaining_reg;
        pad_pending_next    = pad_pending_reg;
        data_seen_next      = data_seen_reg;
        in_data_body_next   = in_data_body_reg;
        payload_count_next  = payload_count_reg;
        rate_seen_next      = rate_seen_reg;
        rate_value_next     = rate_value_reg;
        res                 = '0;

        case (phase_reg)
            PH_RIFF:
            begin
                if (idx4 < 4'd4) begin
                    if (data_byte != RIFF_TAG[8*(3-idx4[1:0]) +: 8]) begin
                        header_ok_next = 1'b0;
                    end
                end else if (idx4 >= 4'd8) begin
                    if (data_byte != WAVE_TAG[8*(3-idx4[1:0]) +: 8]) begin
                        header_ok_next = 1'b0;
                    end
                end
                if (idx4 == RIFF_HDR_BYTES - 4'd1) begin
                    byte_in_field_next = '0;
                    phase_next = header_ok_next ? PH_HDR : PH_DEAD;
                end else begin
                    byte_in_field_next = idx4 + 4'd1;
                end
            end
            PH_HDR:
            begin
                if (idx3 == 3'd0) begin
                    chunk_tag_next    = {24'b0, data_byte};
                    chunk_length_next = '0;
                end else if (idx3 < 3'd4) begin
                    chunk_tag_next = {chunk_tag_reg[23:0], data_byte};
                end else begin
                    chunk_length_next = asm_len;
                end
                if ({1'b0, idx3} == CHUNK_HDR_BYTES - 4'd1) begin
                    byte_in_field_next  = '0;
                    pad_pending_next    = asm_len[0];
                    body_remaining_next = len_sat;
                    if (chunk_tag_reg == DATA_TAG && !data_seen_reg) begin
                        data_seen_next     = 1'b1;
                        in_data_body_next  = 1'b1;
                        payload_count_next = '0;
                    end
                    if (len_sat == '0) begin
                        in_data_body_next = 1'b0;
                        phase_next = asm_len[0] ? PH_PAD : PH_HDR;
                    end else if (chunk_tag_reg == FMT_TAG && asm_len >= FMT_MIN_SIZE
                                 && !rate_seen_reg) begin
                        rate_value_next = '0;
                        phase_next      = PH_FMT;
                    end else begin
                        phase_next = PH_BODY;
                    end
                end else begin
                    byte_in_field_next = {1'b0, idx3} + 4'd1;
                end
            end
            PH_BODY, PH_FMT:
            begin
                if (in_data_body_reg) begin
                    res.payload_valid  = 1'b1;
                    res.payload_byte   = data_byte;
                    payload_count_next = payload_count_reg + 1'b1;
                end
                if (phase_reg == PH_FMT) begin
                    if (idx3 >= 3'd4) begin
                        rate_value_next = rate_value_reg
                            | ({24'b0, data_byte} << {idx3[1:0], 3'b000});
                    end
                    if (idx3 == 3'd7) begin
                        rate_seen_next     = 1'b1;
                        phase_next         = PH_BODY;
                        byte_in_field_next = '0;
                    end else begin
                        byte_in_field_next = {1'b0, idx3} + 4'd1;
                    end
                end
                if (body_remaining_reg != '0) begin
                    body_dec = body_remaining_reg - 1'b1;
                end
                body_remaining_next = body_dec;
                if (body_dec == '0) begin
                    in_data_body_next  = 1'b0;
                    byte_in_field_next = '0;
                    phase_next = pad_pending_reg ? PH_PAD : PH_HDR;
                end
            end
            PH_PAD:
            begin
                pad_pending_next   = 1'b0;
                byte_in_field_next = '0;
                phase_next         = PH_HDR;
            end
            default:
            begin
            end
        endcase

        if (end_of_buffer) begin
            cnt_ext          = {32'b0, payload_count_next};
            res.done_res     = 1'b1;
            res.is_wave      = header_ok_next && (phase_next != PH_RIFF);
            res.data_found   = data_seen_next;
            res.data_length  = cnt_ext[31:0];
            res.rate_hz      = rate_seen_next ? rate_value_next : 32'b0;

            phase_next          = PH_RIFF;
            byte_in_field_next  = '0;
            header_ok_next      = 1'b1;
            chunk_tag_next      = '0;
            chunk_length_next   = '0;
            body_remaining_next = '0;
            pad_pending_next    = 1'b0;
            data_seen_next      = 1'b0;
            in_data_body_next   = 1'b0;
            payload_count_next  = '0;
            rate_seen_next      = 1'b0;
            rate_value_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg          <= PH_RIFF;
            byte_in_field_reg  <= '0;
            header_ok_reg      <= 1'b1;
            chunk_tag_reg      <= '0;
            chunk_length_reg   <= '0;
            body_remaining_reg <= '0;
            pad_pending_reg    <= 1'b0;
            data_seen_reg      <= 1'b0;
            in_data_body_reg   <= 1'b0;
            payload_count_reg  <= '0;
            rate_seen_reg      <= 1'b0;
            rate_value_reg     <= '0;
        end else if (src_fire) begin
            phase_reg          <= phase_next;
            byte_in_field_reg  <= byte_in_field_next;
            header_ok_reg      <= header_ok_next;
            chunk_tag_reg      <= chunk_tag_next;
            chunk_length_reg   <= chunk_length_next;
            body_remaining_reg <= body_remaining_next;
            pad_pending_reg    <= pad_pending_next;
            data_seen_reg      <= data_seen_next;
            in_data_body_reg   <= in_data_body_next;
            payload_count_reg  <= payload_count_next;
            rate_seen_reg      <= rate_seen_next;
            rate_value_reg     <= rate_value_next;
        end
    end

    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (dst_fire || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = res;
                out_valid_next = src_fire;
            end
        end else if (src_fire) begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign dst_valid     = out_valid_reg;
    assign payload_valid = out_reg.payload_valid;
    assign payload_byte  = out_reg.payload_byte;
    assign done_res      = out_reg.done_res;
    assign is_wave       = out_reg.is_wave;
    assign data_found    = out_reg.data_found;
    assign data_length   = out_reg.data_length;
    assign rate_hz       = out_reg.rate_hz;

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while result register empty");

    a_summary_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && !done_res) |-> (!is_wave && !data_found
                                      && data_length == 32'd0 && rate_hz == 32'd0))
        else $error("summary fields set on an item that is not the last byte");

    a_no_payload_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && !payload_valid) |-> (payload_byte == 8'd0))
        else $error("payload byte nonzero without payload_valid");

    a_not_wave_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && done_res && !is_wave) |-> (!data_found && rate_hz == 32'd0))
        else $error("chunk results reported for a buffer that is not WAVE");

endmodule
